[hdl/hkl_pkg.sv]
// shared types and constants for the histogram kl divergence block
`timescale 1ns / 1ps
package hkl_pkg;

  localparam int MANT_BITS = 30;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam int LN2_BITS = 32;
  localparam int CNT_W = 32;
  localparam int TOTAL_W = 40;
  localparam int SUM_W = 48;
  localparam int CFG_IDX_W = 4;
  localparam logic [63:0] SUM_MAX = 64'h0000_7FFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_REF = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CAND = 4'd1;

  typedef struct packed {
    logic term_en;
    logic final_bin;
    logic overflow;
  } hkl_flags_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } hkl_front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NORM,
    BK_LOG,
    BK_DIFF,
    BK_MLN,
    BK_MID,
    BK_MTERM,
    BK_ACC,
    BK_EMIT
  } hkl_back_state_t;

endpackage

[hdl/hkl_if.sv]
// request channel interfaces for the histogram kl divergence block
`timescale 1ns / 1ps
interface hkl_in_if import hkl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] reference_count;
  logic [CNT_W-1:0] candidate_count;
  logic             final_bin;
  modport source(output valid, reference_count, candidate_count, final_bin, input ready);
  modport sink(input valid, reference_count, candidate_count, final_bin, output ready);
endinterface

interface hkl_out_if import hkl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] divergence;
  logic                    bin_overflow;
  modport source(output valid, divergence, bin_overflow, input ready);
  modport sink(input valid, divergence, bin_overflow, output ready);
endinterface

interface hkl_cfg_if import hkl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TOTAL_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/hkl_front.sv]
// front end: bin counting, overflow marking and normalising division
`timescale 1ns / 1ps
module hkl_front import hkl_pkg::*; #(
  parameter int FRAC_BITS = 32,
  parameter int MAX_BINS  = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hkl_in_if.sink               in_ch,
  hkl_cfg_if.sink              cfg_ch,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [FRAC_BITS-1:0] push_p,
  output logic [FRAC_BITS-1:0] push_q,
  output hkl_flags_t           push_flags
);

  localparam int BIN_W  = $clog2(MAX_BINS + 1);
  localparam int ITER_W = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS-1:0] FULL = '1;

  hkl_front_state_t     state_r, state_nxt;
  logic [TOTAL_W-1:0]   tot_ref_r, tot_cand_r;
  logic [TOTAL_W-1:0]   rem_p_r, rem_q_r;
  logic [FRAC_BITS-1:0] quo_p_r, quo_q_r;
  logic                 zero_p_r, zero_q_r, full_p_r, full_q_r;
  logic                 final_r, skip_r;
  logic [ITER_W-1:0]    iter_r;
  logic [BIN_W-1:0]     bins_r;
  logic                 ovf_r;

  logic               accept;
  logic               div_last;
  logic [TOTAL_W:0]   sh_p, sh_q;
  logic               ge_p, ge_q;
  logic [TOTAL_W-1:0] rem_p_nxt, rem_q_nxt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_ref_r  <= TOTAL_W'(1);
      tot_cand_r <= TOTAL_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TOTAL_REF:  tot_ref_r  <= cfg_ch.data;
        CFG_TOTAL_CAND: tot_cand_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign div_last = (iter_r == ITER_W'(FRAC_BITS - 1));

  // one restoring step per lane
  always_comb begin
    sh_p      = {rem_p_r, 1'b0};
    sh_q      = {rem_q_r, 1'b0};
    ge_p      = sh_p >= {1'b0, tot_ref_r};
    ge_q      = sh_q >= {1'b0, tot_cand_r};
    rem_p_nxt = ge_p ? TOTAL_W'(sh_p - {1'b0, tot_ref_r}) : sh_p[TOTAL_W-1:0];
    rem_q_nxt = ge_q ? TOTAL_W'(sh_q - {1'b0, tot_cand_r}) : sh_q[TOTAL_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: begin
        if (accept) state_nxt = (bins_r >= BIN_W'(MAX_BINS)) ? FR_PUSH : FR_DIV;
      end
      FR_DIV: begin
        if (div_last) state_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        if (push_ready) state_nxt = FR_IDLE;
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    case (state_r)
      FR_IDLE: in_ch.ready = 1'b1;
      FR_PUSH: push_valid  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    push_p = zero_p_r ? '0 : (full_p_r ? FULL : quo_p_r);
    push_q = zero_q_r ? '0 : (full_q_r ? FULL : quo_q_r);
    push_flags.term_en   = !skip_r && (push_p != '0) && (push_q != '0);
    push_flags.final_bin = final_r;
    push_flags.overflow  = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      bins_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (bins_r >= BIN_W'(MAX_BINS)) ovf_r <= 1'b1;
        else                            bins_r <= bins_r + 1'b1;
      end
      if (push_valid && push_ready && final_r) begin
        bins_r <= '0;
        ovf_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem_p_r  <= TOTAL_W'(in_ch.reference_count);
      rem_q_r  <= TOTAL_W'(in_ch.candidate_count);
      zero_p_r <= in_ch.reference_count == '0;
      zero_q_r <= in_ch.candidate_count == '0;
      full_p_r <= TOTAL_W'(in_ch.reference_count) >= tot_ref_r;
      full_q_r <= TOTAL_W'(in_ch.candidate_count) >= tot_cand_r;
      final_r  <= in_ch.final_bin;
      skip_r   <= bins_r >= BIN_W'(MAX_BINS);
      iter_r   <= '0;
    end else if (state_r == FR_DIV) begin
      rem_p_r <= rem_p_nxt;
      rem_q_r <= rem_q_nxt;
      quo_p_r <= {quo_p_r[FRAC_BITS-2:0], ge_p};
      quo_q_r <= {quo_q_r[FRAC_BITS-2:0], ge_q};
      iter_r  <= iter_r + 1'b1;
    end
  end

  a_bins_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bins_r <= BIN_W'(MAX_BINS))
    else $error("bin counter beyond maximum");

endmodule

[hdl/hkl_fifo.sv]
// short queue between the front and back ends
`timescale 1ns / 1ps
module hkl_fifo import hkl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, rptr_r;
  logic [CNT_W_Q-1:0] count_r;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W_Q'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W_Q'(DEPTH))
    else $error("queue fill beyond depth");

endmodule

[hdl/hkl_back.sv]
// back end: iterative log2, serial multiplies and saturating sum
`timescale 1ns / 1ps
module hkl_back import hkl_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [FRAC_BITS-1:0] pop_p,
  input  logic [FRAC_BITS-1:0] pop_q,
  input  hkl_flags_t           pop_flags,
  hkl_out_if.source            out_ch
);

  localparam int F     = FRAC_BITS;
  localparam int MW    = MANT_BITS + 1;
  localparam int INT_W = 8;
  localparam int LW    = F + INT_W;
  localparam int MAGW  = F + 7;
  localparam int MB_W  = (F > LN2_BITS) ? F : LN2_BITS;
  localparam int AW    = MAGW + MB_W;
  localparam int IT_W  = $clog2(MB_W + 1);

  hkl_back_state_t   state_r, state_nxt;
  hkl_flags_t        flags_r;
  logic [F-1:0]      xp_r, xq_r, p_r, fp_r, fq_r;
  logic [IT_W-1:0]   np_r, nq_r, it_r;
  logic [MW-1:0]     mp_r, mq_r;
  logic              neg_r;
  logic [AW-1:0]     ms_r, acc_r;
  logic [MB_W-1:0]   mb_r;
  logic signed [SUM_W-1:0] sum_r;
  logic              out_valid_r;
  logic signed [SUM_W-1:0] out_div_r;
  logic              out_ovf_r;

  logic              norm_done, out_free;
  logic [2*MW-1:0]   sq_p, sq_q;
  logic [MW:0]       hp, hq;
  logic [MW-1:0]     mp_nxt, mq_nxt;
  logic signed [LW-1:0] lp, lq, dlog;
  logic [LW-1:0]     mag_full;
  logic [AW-1:0]     acc_step;
  logic [MAGW-1:0]   term, ln_val;
  logic [SUM_W-1:0]  term_cl;
  logic signed [SUM_W:0] sum_ext, sum_tmp;
  logic signed [SUM_W-1:0] sum_sat;

  assign norm_done = xp_r[F-1] && xq_r[F-1];
  assign out_free  = !out_valid_r || out_ch.ready;

  // one squaring step of the log2 iteration per lane
  always_comb begin
    sq_p   = mp_r * mp_r;
    sq_q   = mq_r * mq_r;
    hp     = (MW + 1)'(sq_p >> MANT_BITS);
    hq     = (MW + 1)'(sq_q >> MANT_BITS);
    mp_nxt = hp[MW] ? hp[MW:1] : hp[MW-1:0];
    mq_nxt = hq[MW] ? hq[MW:1] : hq[MW-1:0];
  end

  always_comb begin
    lp = $signed({{INT_W{1'b0}}, fp_r}) - $signed({INT_W'(np_r) + INT_W'(1), F'(0)});
    lq = $signed({{INT_W{1'b0}}, fq_r}) - $signed({INT_W'(nq_r) + INT_W'(1), F'(0)});
    dlog = lp - lq;
    mag_full = dlog[LW-1] ? LW'(-dlog) : LW'(dlog);
  end

  assign acc_step = acc_r + (mb_r[0] ? ms_r : '0);
  assign ln_val   = MAGW'(acc_r >> LN2_BITS);
  assign term     = MAGW'(acc_r >> F);

  always_comb begin
    term_cl = (64'(term) > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : SUM_W'(term);
    sum_ext = {sum_r[SUM_W-1], sum_r};
    sum_tmp = neg_r ? sum_ext - $signed({1'b0, term_cl}) : sum_ext + $signed({1'b0, term_cl});
    if (sum_tmp[SUM_W] != sum_tmp[SUM_W-1])
      sum_sat = sum_tmp[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_sat = sum_tmp[SUM_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) state_nxt = pop_flags.term_en ? BK_NORM : BK_ACC;
      end
      BK_NORM: begin
        if (norm_done) state_nxt = BK_LOG;
      end
      BK_LOG: begin
        if (it_r == IT_W'(F - 1)) state_nxt = BK_DIFF;
      end
      BK_DIFF: state_nxt = BK_MLN;
      BK_MLN: begin
        if (it_r == IT_W'(LN2_BITS - 1)) state_nxt = BK_MID;
      end
      BK_MID: state_nxt = BK_MTERM;
      BK_MTERM: begin
        if (it_r == IT_W'(F - 1)) state_nxt = BK_ACC;
      end
      BK_ACC: state_nxt = flags_r.final_bin ? BK_EMIT : BK_IDLE;
      BK_EMIT: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    case (state_r)
      BK_IDLE: pop_ready = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.divergence   = out_div_r;
  assign out_ch.bin_overflow = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_ACC && flags_r.term_en) sum_r <= sum_sat;
      if (state_r == BK_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_EMIT && out_free) begin
      out_div_r <= sum_r;
      out_ovf_r <= flags_r.overflow;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          flags_r <= pop_flags;
          xp_r    <= pop_p;
          xq_r    <= pop_q;
          p_r     <= pop_p;
          np_r    <= '0;
          nq_r    <= '0;
        end
      end
      BK_NORM: begin
        if (norm_done) begin
          // align the normalised value to a 1.30 mantissa
          mp_r <= MW'({xp_r, MANT_BITS'(0)} >> (F - 1));
          mq_r <= MW'({xq_r, MANT_BITS'(0)} >> (F - 1));
          fp_r <= '0;
          fq_r <= '0;
          it_r <= '0;
        end else begin
          if (!xp_r[F-1]) begin
            xp_r <= {xp_r[F-2:0], 1'b0};
            np_r <= np_r + 1'b1;
          end
          if (!xq_r[F-1]) begin
            xq_r <= {xq_r[F-2:0], 1'b0};
            nq_r <= nq_r + 1'b1;
          end
        end
      end
      BK_LOG: begin
        mp_r <= mp_nxt;
        mq_r <= mq_nxt;
        fp_r <= {fp_r[F-2:0], hp[MW]};
        fq_r <= {fq_r[F-2:0], hq[MW]};
        it_r <= it_r + 1'b1;
      end
      BK_DIFF: begin
        neg_r <= dlog[LW-1];
        ms_r  <= AW'(mag_full);
        mb_r  <= MB_W'(LN2_Q32);
        acc_r <= '0;
        it_r  <= '0;
      end
      BK_MLN, BK_MTERM: begin
        acc_r <= acc_step;
        ms_r  <= {ms_r[AW-2:0], 1'b0};
        mb_r  <= mb_r >> 1;
        it_r  <= it_r + 1'b1;
      end
      BK_MID: begin
        // ln of the ratio times p, over the bits of p
        ms_r  <= AW'(ln_val);
        mb_r  <= MB_W'(p_r);
        acc_r <= '0;
        it_r  <= '0;
      end
      default: ;
    endcase
  end

  a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LOG) |-> (mp_r[MANT_BITS] && mq_r[MANT_BITS]))
    else $error("log2 mantissa left the range one to two");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT && out_free) |=> (sum_r == '0 && out_valid_r))
    else $error("emit did not present result and clear the sum");

endmodule

[hdl/histogram_kl_divergence.sv]
// top level of the histogram kl divergence block
`timescale 1ns / 1ps
// Takes one bin pair per request, normalises each count by its configured total
// with a restoring divider (both lanes side by side) and hands the pair
// through a two-entry queue to the back end. The back end finds log2 of both
// fractions by normalising one bit a cycle and then FRAC_BITS squaring steps,
// then forms ln(p/q) and p*ln with a shared shift-add multiplier, stepping
// first through the bits of the ln2 constant and then through those of p, and
// adds the term to a saturating Q15.FRAC_BITS sum. The time a bin with a
// contributing term spends in the back end depends on the leading zeros of
// the smaller fraction, and the back end sets the sustained rate; neither end
// takes a new bin before it is through with the last. Bins with a zero
// fraction or past MAX_BINS skip the log and multiply steps. The result goes
// out on the final bin from an output register that frees the back end.
module histogram_kl_divergence import hkl_pkg::*; #(
  parameter int MAX_BINS  = 2048,
  parameter int FRAC_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hkl_in_if.sink     in_ch,
  hkl_out_if.source  out_ch,
  hkl_cfg_if.sink    cfg_ch
);

  localparam int QW = 2 * FRAC_BITS + $bits(hkl_flags_t);

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic [FRAC_BITS-1:0] push_p, push_q, pop_p, pop_q;
  hkl_flags_t           push_flags, pop_flags;
  logic [QW-1:0]        push_data, pop_data;

  assign push_data = {push_p, push_q, push_flags};
  assign {pop_p, pop_q, pop_flags} = pop_data;

  hkl_front #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_p    (push_p),
    .push_q    (push_q),
    .push_flags(push_flags)
  );

  hkl_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  hkl_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_p    (pop_p),
    .pop_q    (pop_q),
    .pop_flags(pop_flags),
    .out_ch   (out_ch)
  );

endmodule

[tb/histogram_kl_divergence_test.sv]
// self-checking testbench for the histogram kl divergence block
`timescale 1ns / 1ps
module histogram_kl_divergence_test;
  import hkl_pkg::*;

  localparam int BIN_LIMIT = 2048;
  localparam int FBITS = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd7;
  localparam logic [TOTAL_W-1:0] TOTAL_TOP = {TOTAL_W{1'b1}};
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [CNT_W-1:0] ref_cnt;
    logic [CNT_W-1:0] cand_cnt;
    logic             last;
  } bin_req_t;

  typedef struct {
    logic signed [SUM_W-1:0] div;
    logic                    ovf;
  } kl_result_t;

  logic clk;
  logic rst_n;

  hkl_in_if  in_if();
  hkl_out_if out_if();
  hkl_cfg_if cfg_if();

  histogram_kl_divergence u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bin_req_t   bin_q[$];
  kl_result_t kl_expected_q[$];
  int         errors;
  logic       in_taken;
  logic       cfg_taken;
  logic       quiet;
  int         send_gap;
  int         recv_stall;

  // predictor state
  logic [TOTAL_W-1:0] tot_ref_m;
  logic [TOTAL_W-1:0] tot_cand_m;
  longint             kl_sum_m;
  int                 bins_m;
  logic               ovf_m;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] normalise(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = '0;
    if (num == 0) return '0;
    if (num >= den) return (64'd1 << FBITS) - 64'd1;
    for (int i = 0; i < FBITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // (a*b) >> s with saturation to 64 bits
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    if ((prod >> (64 + s)) != 0) return {64{1'b1}};
    prod = prod >> s;
    return prod[63:0];
  endfunction

  function automatic longint log2_q(logic [63:0] x);
    int          k;
    logic [63:0] mant;
    logic [63:0] frac;
    k = FBITS - 1;
    frac = '0;
    while (k > 0 && x[k] == 1'b0) k--;
    if (k >= MANT_BITS) mant = x >> (k - MANT_BITS);
    else mant = x << (MANT_BITS - k);
    for (int i = 1; i <= FBITS; i++) begin
      mant = (mant * mant) >> MANT_BITS;
      if (mant >= (64'd2 << MANT_BITS)) begin
        mant = mant >> 1;
        frac[FBITS-i] = 1'b1;
      end
    end
    return longint'(frac) - longint'(64'(FBITS - k) << FBITS);
  endfunction

  task automatic accumulate_bin(bin_req_t b);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] mag;
    logic [63:0] ln_mag;
    logic [63:0] term;
    longint      d;
    kl_result_t  r;
    if (bins_m >= BIN_LIMIT) begin
      ovf_m = 1'b1;
    end else begin
      p = normalise(64'(b.ref_cnt), 64'(tot_ref_m));
      q = normalise(64'(b.cand_cnt), 64'(tot_cand_m));
      bins_m++;
      if (p != 0 && q != 0) begin
        d = log2_q(p) - log2_q(q);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        ln_mag = scaled_product(mag, 64'(LN2_Q32), LN2_BITS);
        term = scaled_product(p, ln_mag, FBITS);
        if (term > 64'(SUM_HI)) term = 64'(SUM_HI);
        if (d < 0) begin
          kl_sum_m = kl_sum_m - longint'(term);
          if (kl_sum_m < SUM_LO) kl_sum_m = SUM_LO;
        end else begin
          kl_sum_m = kl_sum_m + longint'(term);
          if (kl_sum_m > SUM_HI) kl_sum_m = SUM_HI;
        end
      end
    end
    if (b.last) begin
      r.div = kl_sum_m[SUM_W-1:0];
      r.ovf = ovf_m;
      kl_expected_q = {kl_expected_q, r};
      kl_sum_m = 0;
      bins_m = 0;
      ovf_m = 1'b0;
    end
  endtask

  // monitor: sample handshakes at the rising edge
  always @(posedge clk) begin
    bin_req_t   b;
    kl_result_t e;
    in_taken  <= in_if.valid && in_if.ready;
    cfg_taken <= cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_TOTAL_REF) tot_ref_m = cfg_if.data;
        else if (cfg_if.index == CFG_TOTAL_CAND) tot_cand_m = cfg_if.data;
      end
      if (out_if.valid && out_if.ready) begin
        if (kl_expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual div=%0d ovf=%0b",
                   $time, out_if.divergence, out_if.bin_overflow);
        end else begin
          e = kl_expected_q.pop_front();
          if (out_if.divergence !== e.div) begin
            errors++;
            $display("%0t: divergence mismatch: expected %0d, actual %0d",
                     $time, e.div, out_if.divergence);
          end
          if (out_if.bin_overflow !== e.ovf) begin
            errors++;
            $display("%0t: bin_overflow mismatch: expected %0b, actual %0b",
                     $time, e.ovf, out_if.bin_overflow);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        b.ref_cnt  = in_if.reference_count;
        b.cand_cnt = in_if.candidate_count;
        b.last     = in_if.final_bin;
        accumulate_bin(b);
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    bin_req_t b;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (bin_q.size() > 0) begin
        b = bin_q.pop_front();
        in_if.reference_count <= b.ref_cnt;
        in_if.candidate_count <= b.cand_cnt;
        in_if.final_bin <= b.last;
        in_if.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_if.ready <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      recv_stall <= $urandom_range(0, 15);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic push_bin(logic [CNT_W-1:0] rc, logic [CNT_W-1:0] cc, logic last);
    bin_req_t b;
    b.ref_cnt = rc;
    b.cand_cnt = cc;
    b.last = last;
    bin_q = {bin_q, b};
  endtask

  task automatic write_total(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] val);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data <= val;
    cfg_if.valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every request is in and every result is out, then let the back end settle
  task automatic drain();
    do @(negedge clk);
    while (bin_q.size() != 0 || (in_if.valid && !in_taken) || kl_expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [TOTAL_W-1:0] pick_total();
    case ($urandom_range(0, 5))
      0: return TOTAL_W'(1);
      1: return TOTAL_TOP;
      2: return TOTAL_W'($urandom_range(1, 1000));
      3: return {8'd0, $urandom} + TOTAL_W'(1);
      4: return {8'($urandom_range(0, 255)), $urandom};
      default: return TOTAL_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count(logic [TOTAL_W-1:0] tot);
    logic [TOTAL_W-1:0] lim;
    lim = (tot > 40'hFFFF_FFFF) ? 40'hFFFF_FFFF : tot;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom;
      2: return CNT_W'($urandom_range(1, 255));
      3: return {2'($urandom_range(0, 3)), 30'd0} | ($urandom >> 4);
      default: return CNT_W'((64'($urandom) * 64'(lim)) >> 32);
    endcase
  endfunction

  initial begin
    int       len;
    bin_req_t b;
    errors = 0;
    quiet = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    in_taken = 1'b0;
    cfg_taken = 1'b0;
    tot_ref_m = 1;
    tot_cand_m = 1;
    kl_sum_m = 0;
    bins_m = 0;
    ovf_m = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.reference_count = '0;
    in_if.candidate_count = '0;
    in_if.final_bin = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TOTAL_REF;
    cfg_if.data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset totals of one: every nonzero count saturates to a full fraction
    push_bin(0, 0, 1'b0);
    push_bin(0, 5, 1'b0);
    push_bin(5, 0, 1'b0);
    push_bin('1, '1, 1'b0);
    push_bin(1, '1, 1'b1);
    push_bin(7, 3, 1'b1);
    drain();

    // widest totals, extremes of the counts
    write_total(CFG_TOTAL_REF, TOTAL_TOP);
    write_total(CFG_TOTAL_CAND, TOTAL_TOP);
    write_total(CFG_SPARE_IDX, 40'd5);
    push_bin('1, 1, 1'b0);
    push_bin(1, '1, 1'b0);
    push_bin('1, '1, 1'b0);
    push_bin(255, 256, 1'b0);
    push_bin(256, 255, 1'b1);
    drain();

    // a zero reference total, and counts above the total
    write_total(CFG_TOTAL_REF, 40'd0);
    write_total(CFG_TOTAL_CAND, 40'd3);
    push_bin(0, 9, 1'b0);
    push_bin(4, 0, 1'b0);
    push_bin(4, 9, 1'b0);
    push_bin(0, 2, 1'b0);
    push_bin('1, 1, 1'b1);
    drain();

    // full p against tiny q: drives the sum to saturation and past the bin limit
    write_total(CFG_TOTAL_REF, 40'd1);
    write_total(CFG_TOTAL_CAND, TOTAL_TOP);
    for (int i = 0; i < BIN_LIMIT + 3; i++)
      push_bin($urandom | 32'd1, 32'd256, i == BIN_LIMIT + 2);
    push_bin(3, 300, 1'b1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      write_total(CFG_TOTAL_REF, pick_total());
      write_total(CFG_TOTAL_CAND, pick_total());
      if (ph == 8) quiet = 1'b1;
      for (int n = 0; n < 100; n += len) begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++)
          push_bin(pick_count(tot_ref_m), pick_count(tot_cand_m), j == len - 1);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
